// ===== design/hrhp_pkg.sv =====
// Shared types and constants for the HTTP response header parser.
package hrhp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned NUM_W     = 16;
    localparam int unsigned PROD_W    = NUM_W + 4;

    // pattern lengths
    localparam int unsigned STATUS_LEN = 9;
    localparam int unsigned LENGTH_LEN = 17;
    localparam int unsigned BLANK_LEN  = 4;
    localparam int unsigned STATUS_PW  = 4;
    localparam int unsigned LENGTH_PW  = 5;
    localparam int unsigned BLANK_PW   = 3;

    // ASCII codes
    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7a;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_LF      = 8'h0a;

    // configuration register indexes
    localparam logic REG_HDR_PASS     = 1'b0;
    localparam logic REG_BYTE_LIMIT   = 1'b1;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;

    // result stream layout, lowest bit first
    localparam int unsigned OD_BYTE_LO   = 0;
    localparam int unsigned OD_IN_BODY   = 8;
    localparam int unsigned OD_STATUS_LO = 9;
    localparam int unsigned OD_LENGTH_LO = 25;
    localparam int unsigned OD_LEN_SEEN  = 41;
    localparam int unsigned OD_DONE      = 42;
    localparam int unsigned OD_USED_W    = 43;
    localparam int unsigned OD_W         = 48;

    typedef struct packed {
        logic status_arm;   // "HTTP/1.1 " just completed
        logic length_arm;   // "\r\nCONTENT-LENGTH:" just completed
        logic blank_done;   // blank line just completed
    } t_match_hit;

    function automatic logic [BYTE_W-1:0] status_char(input logic [STATUS_PW-1:0] pos);
        logic [BYTE_W-1:0] c;
        c = '0;
        case (pos)
            4'd0:    c = 8'h48; // H
            4'd1:    c = 8'h54; // T
            4'd2:    c = 8'h54; // T
            4'd3:    c = 8'h50; // P
            4'd4:    c = 8'h2f; // /
            4'd5:    c = 8'h31; // 1
            4'd6:    c = 8'h2e; // .
            4'd7:    c = 8'h31; // 1
            4'd8:    c = CH_SPACE;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] length_char(input logic [LENGTH_PW-1:0] pos);
        logic [BYTE_W-1:0] c;
        c = '0;
        case (pos)
            5'd0:    c = CH_CR;
            5'd1:    c = CH_LF;
            5'd2:    c = 8'h43; // C
            5'd3:    c = 8'h4f; // O
            5'd4:    c = 8'h4e; // N
            5'd5:    c = 8'h54; // T
            5'd6:    c = 8'h45; // E
            5'd7:    c = 8'h4e; // N
            5'd8:    c = 8'h54; // T
            5'd9:    c = 8'h2d; // -
            5'd10:   c = 8'h4c; // L
            5'd11:   c = 8'h45; // E
            5'd12:   c = 8'h4e; // N
            5'd13:   c = 8'h47; // G
            5'd14:   c = 8'h54; // T
            5'd15:   c = 8'h48; // H
            5'd16:   c = 8'h3a; // :
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] blank_char(input logic [BLANK_PW-1:0] pos);
        return pos[0] ? CH_LF : CH_CR;
    endfunction

endpackage

// ===== design/http_response_header_parser.sv =====
// HTTP response header parser: top level, number accumulator and body counters.
//
//  channel  | dir | handshake                        | payload
//  s_axis   | in  | s_axis_tvalid / s_axis_tready    | tdata[7:0] data_byte
//  m_axis   | out | m_axis_tvalid / m_axis_tready    | tdata: see port, tuser: out_valid
//  apb      | in  | psel & penable & pwrite & pready | 0x0 hdr_pass, 0x4 byte_limit
//
// One byte per cycle unless the output stalls: a byte is parsed in the cycle
// it is taken and its result sits in the output register on the next cycle; the
// single output register sets the latency. A new byte is taken whenever that
// register is empty or being drained. Reset is synchronous and clears all parse
// state; byte_limit writes also reload the remaining forward budget.
module http_response_header_parser #(
    parameter int unsigned MAX_DIGITS = 11
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [hrhp_pkg::BYTE_W-1:0]    s_axis_tdata,  // [7:0] data_byte
    // master stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] out_byte, [8] in_body, [24:9] status_code, [40:25] content_length,
    // [41] length_seen, [42] done_res, [47:43] zero
    output logic [hrhp_pkg::OD_W-1:0]      m_axis_tdata,
    output logic                           m_axis_tuser,  // [0] out_valid
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hrhp_pkg::PADDR_W-1:0]   paddr,
    input  logic [hrhp_pkg::PDATA_W-1:0]   pwdata,
    output logic [hrhp_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import hrhp_pkg::*;

    localparam int unsigned DCW = $clog2(MAX_DIGITS + 2);

    // configuration
    logic              r_hdr_pass;
    logic [NUM_W-1:0]  r_byte_limit;
    logic              w_cfg_wr;

    // parse state
    logic [DCW-1:0]    r_digit_count, n_digit_count;
    logic              r_number_kind, n_number_kind;
    logic [NUM_W-1:0]  r_number_value, n_number_value;
    logic [NUM_W-1:0]  r_status_reg, n_status_reg;
    logic [NUM_W-1:0]  r_length_reg, n_length_reg;
    logic              r_length_flag, n_length_flag;
    logic              r_body_flag, n_body_flag;
    logic [NUM_W-1:0]  r_body_remaining, n_body_remaining;
    logic [NUM_W-1:0]  r_room_left, n_room_left;
    logic              r_finished, n_finished;

    // output stage
    logic              r_m_tvalid;
    logic [OD_W-1:0]   r_m_tdata, n_m_tdata;
    logic              r_m_tuser, n_m_tuser;

    logic              w_accept;
    logic              w_hdr_en;
    logic [BYTE_W-1:0] w_ch;
    logic              w_is_digit;
    logic              w_fwd;
    logic [PROD_W-1:0] w_prod;
    t_match_hit        w_hit;

    assign pready        = 1'b1;
    assign w_cfg_wr      = psel & penable & pwrite & pready;
    assign prdata        = (paddr[2] == REG_BYTE_LIMIT) ? PDATA_W'(r_byte_limit)
                                                        : PDATA_W'(r_hdr_pass);

    assign s_axis_tready = !r_m_tvalid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_hdr_en      = w_accept && !r_finished && !r_body_flag;

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    // case fold, a-z only
    always_comb begin
        w_ch = s_axis_tdata;
        if (s_axis_tdata >= CH_LOWER_A && s_axis_tdata <= CH_LOWER_Z) begin
            w_ch = s_axis_tdata - 8'd32;
        end
    end

    always_comb begin
        w_is_digit = 1'b0;
        case (w_ch) inside
            [CH_ZERO:CH_NINE]: w_is_digit = 1'b1;
            default:           w_is_digit = 1'b0;
        endcase
    end

    // value * 10 + digit, as two shifts and two adds
    assign w_prod = PROD_W'({r_number_value, 3'b000}) + PROD_W'({r_number_value, 1'b0})
                  + PROD_W'(w_ch[3:0]);

    hrhp_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_hdr_en),
        .i_ch    (w_ch),
        .o_hit   (w_hit)
    );

    always_comb begin
        n_digit_count    = r_digit_count;
        n_number_kind    = r_number_kind;
        n_number_value   = r_number_value;
        n_status_reg     = r_status_reg;
        n_length_reg     = r_length_reg;
        n_length_flag    = r_length_flag;
        n_body_flag      = r_body_flag;
        n_body_remaining = r_body_remaining;
        n_room_left      = r_room_left;
        n_finished       = r_finished;
        w_fwd            = 1'b0;

        if (w_accept && !r_finished) begin
            if (!r_body_flag) begin
                if (r_digit_count != '0) begin
                    if (w_is_digit) begin
                        if (r_digit_count <= DCW'(MAX_DIGITS)) begin
                            n_number_value = (|w_prod[PROD_W-1:NUM_W]) ? '1
                                                                       : w_prod[NUM_W-1:0];
                            n_digit_count  = r_digit_count + 1'b1;
                        end
                    end else if (!(w_ch == CH_SPACE && r_digit_count == DCW'(1))) begin
                        if (r_digit_count > DCW'(1)) begin
                            if (r_number_kind) begin
                                n_length_reg  = r_number_value;
                                n_length_flag = 1'b1;
                            end else begin
                                n_status_reg = r_number_value;
                            end
                        end
                        n_digit_count = '0;
                    end
                end
                // a fresh pattern drops any open number
                if (w_hit.status_arm || w_hit.length_arm) begin
                    n_digit_count  = DCW'(1);
                    n_number_kind  = w_hit.length_arm;
                    n_number_value = '0;
                end
                if (w_hit.blank_done) begin
                    n_body_flag      = 1'b1;
                    n_body_remaining = n_length_reg;
                end
                w_fwd = r_hdr_pass;
                if (n_body_flag && n_length_flag && n_length_reg == '0) begin
                    n_finished = 1'b1;
                end
            end else begin
                w_fwd = 1'b1;
                if (r_length_flag) begin
                    if (r_body_remaining != '0) begin
                        n_body_remaining = r_body_remaining - 1'b1;
                    end
                    if (r_body_remaining <= NUM_W'(1)) begin
                        n_finished = 1'b1;
                    end
                end
            end
            if (w_fwd && r_byte_limit != '0) begin
                if (r_room_left != '0) begin
                    n_room_left = r_room_left - 1'b1;
                end
                if (r_room_left <= NUM_W'(1)) begin
                    n_finished = 1'b1;
                end
            end
        end

        if (w_cfg_wr && paddr[2] == REG_BYTE_LIMIT) begin
            n_room_left = pwdata[NUM_W-1:0];
        end
    end

    always_comb begin
        n_m_tdata                                 = '0;
        n_m_tdata[OD_BYTE_LO +: BYTE_W]           = w_fwd ? s_axis_tdata : '0;
        n_m_tdata[OD_IN_BODY]                     = n_body_flag;
        n_m_tdata[OD_STATUS_LO +: NUM_W]          = n_status_reg;
        n_m_tdata[OD_LENGTH_LO +: NUM_W]          = n_length_reg;
        n_m_tdata[OD_LEN_SEEN]                    = n_length_flag;
        n_m_tdata[OD_DONE]                        = n_finished;
        n_m_tuser                                 = w_fwd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pass       <= 1'b0;
            r_byte_limit     <= '0;
            r_digit_count    <= '0;
            r_number_kind    <= 1'b0;
            r_number_value   <= '0;
            r_status_reg     <= '0;
            r_length_reg     <= '0;
            r_length_flag    <= 1'b0;
            r_body_flag      <= 1'b0;
            r_body_remaining <= '0;
            r_room_left      <= '0;
            r_finished       <= 1'b0;
            r_m_tvalid       <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                if (paddr[2] == REG_HDR_PASS) begin
                    r_hdr_pass <= pwdata[0];
                end else begin
                    r_byte_limit <= pwdata[NUM_W-1:0];
                end
            end
            r_digit_count    <= n_digit_count;
            r_number_kind    <= n_number_kind;
            r_number_value   <= n_number_value;
            r_status_reg     <= n_status_reg;
            r_length_reg     <= n_length_reg;
            r_length_flag    <= n_length_flag;
            r_body_flag      <= n_body_flag;
            r_body_remaining <= n_body_remaining;
            r_room_left      <= n_room_left;
            r_finished       <= n_finished;
            if (w_accept) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each transaction taken
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_tdata <= n_m_tdata;
            r_m_tuser <= n_m_tuser;
        end
    end

endmodule

// ===== design/hrhp_match.sv =====
// Pattern matchers for the status line, Content-Length tag and blank line.
module hrhp_match (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [hrhp_pkg::BYTE_W-1:0] i_ch,
    output hrhp_pkg::t_match_hit      o_hit
);
    import hrhp_pkg::*;

    logic [STATUS_PW-1:0] r_status_pos, n_status_pos;
    logic                 r_status_matched, n_status_matched;
    logic [LENGTH_PW-1:0] r_length_pos, n_length_pos;
    logic [BLANK_PW-1:0]  r_blank_pos, n_blank_pos;

    always_comb begin
        n_status_pos     = r_status_pos;
        n_status_matched = r_status_matched;
        n_length_pos     = r_length_pos;
        n_blank_pos      = r_blank_pos;
        o_hit            = '0;

        if (!r_status_matched) begin
            if (r_status_pos < STATUS_PW'(STATUS_LEN) && i_ch == status_char(r_status_pos)) begin
                if (r_status_pos == STATUS_PW'(STATUS_LEN - 1)) begin
                    n_status_pos     = '0;
                    n_status_matched = 1'b1;
                    o_hit.status_arm = 1'b1;
                end else begin
                    n_status_pos = r_status_pos + 1'b1;
                end
            end else begin
                n_status_pos = '0;
            end
        end

        if (r_length_pos < LENGTH_PW'(LENGTH_LEN) && i_ch == length_char(r_length_pos)) begin
            if (r_length_pos == LENGTH_PW'(LENGTH_LEN - 1)) begin
                n_length_pos     = '0;
                o_hit.length_arm = 1'b1;
            end else begin
                n_length_pos = r_length_pos + 1'b1;
            end
        end else begin
            n_length_pos = '0;
        end

        if (r_blank_pos < BLANK_PW'(BLANK_LEN) && i_ch == blank_char(r_blank_pos)) begin
            if (r_blank_pos == BLANK_PW'(BLANK_LEN - 1)) begin
                n_blank_pos      = '0;
                o_hit.blank_done = 1'b1;
            end else begin
                n_blank_pos = r_blank_pos + 1'b1;
            end
        end else begin
            n_blank_pos = '0;
        end

        if (!i_en) begin
            o_hit = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status_pos     <= '0;
            r_status_matched <= 1'b0;
            r_length_pos     <= '0;
            r_blank_pos      <= '0;
        end else if (i_en) begin
            r_status_pos     <= n_status_pos;
            r_status_matched <= n_status_matched;
            r_length_pos     <= n_length_pos;
            r_blank_pos      <= n_blank_pos;
        end
    end

endmodule

// ===== design/hrhp_checker.sv =====
// Port-level checks for the HTTP response header parser, bound to the top level.
module hrhp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [hrhp_pkg::OD_W-1:0]     m_axis_tdata,
    input logic                          m_axis_tuser
);
    import hrhp_pkg::*;

    logic r_done_seen;
    logic w_out_acc;

    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done_seen <= 1'b0;
        end else if (w_out_acc && m_axis_tdata[OD_DONE]) begin
            r_done_seen <= 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_seen && w_out_acc |-> m_axis_tdata[OD_DONE] && !m_axis_tuser)
        else $error("transaction forwarded or done dropped after done");

    a_blank_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OD_BYTE_LO +: BYTE_W] == '0)
        else $error("byte not cleared on a dropped transaction");

    a_length_unseen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[OD_LEN_SEEN]
            |-> m_axis_tdata[OD_LENGTH_LO +: NUM_W] == '0)
        else $error("content length reported without being seen");

endmodule

bind http_response_header_parser hrhp_checker u_hrhp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/testbench.sv =====
// Self-checking stream testbench for the HTTP response header parser.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hrhp_pkg::*;

    localparam int MAX_DIGITS  = 11;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              fwd;
        logic              in_body;
        logic [NUM_W-1:0]  status;
        logic [NUM_W-1:0]  clen;
        logic              len_seen;
        logic              done;
    } t_resp;

    typedef struct {
        string txt;
        int    raw;   // >= 0: send this single byte instead of txt
        bit    chk;
        int    st;
        int    ln;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [BYTE_W-1:0]    s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OD_W-1:0]      m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [PDATA_W-1:0]   pwdata        = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    http_response_header_parser #(.MAX_DIGITS(MAX_DIGITS)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // parser model state
    string            status_word = "HTTP/1.1 ";
    string            length_word = "\015\nCONTENT-LENGTH:";
    string            blank_word  = "\015\n\015\n";
    string            cl_name     = "CONTENT-LENGTH:";
    logic             keep_hdr;
    logic [NUM_W-1:0] limit_val;
    logic [3:0]       st_pos;
    logic             status_done;
    logic [4:0]       len_pos;
    logic [2:0]       blank_pos;
    logic [3:0]       digits;
    logic             num_is_len;
    logic [NUM_W-1:0] num_val;
    logic [NUM_W-1:0] status_val;
    logic [NUM_W-1:0] len_val;
    logic             len_known;
    logic             body_flag;
    logic [NUM_W-1:0] body_left;
    logic [NUM_W-1:0] room_left;
    logic             done_flag;

    t_resp pending_resp[$];
    int    err_cnt     = 0;
    int    sent_cnt    = 0;
    int    checked_cnt = 0;
    int    fwd_cnt     = 0;
    int    stall_cnt   = 0;
    int    cycle_cnt   = 0;
    int    tx_idle_pct = 0;
    int    rx_idle_pct = 50;
    int    hold_req    = 0;
    int    hold_done   = 0;
    int    hold_left   = 0;

    t_dir_row dir_rows [17] = '{
        '{"", 0, 1, 0, 0},
        '{"", 255, 0, 0, 0},
        '{"HTTP/1.0 404\015\n", -1, 1, 0, 0},
        '{"hTtP/1.1  99999999999999 OK", -1, 1, 65535, 0},
        '{"\015\ncontent-length: 0", -1, 0, 0, 0},
        '{"\015\n", -1, 1, 65535, 0},
        '{"CONTENT-LENGTH:65534\015\n", -1, 1, 65535, 65534},
        '{"Content-Length:65536\015\n", -1, 1, 65535, 65535},
        '{"Content-Length:x12\015\n", -1, 1, 65535, 65535},
        '{"content-length:  0000000004299\015\n", -1, 1, 65535, 42},
        '{"Content-Length: 7 7\015\n", -1, 1, 65535, 7},
        // the CR that breaks the match is not retried as a new start
        '{"Content-Lengt\015\nContent-Length:19\015\n", -1, 1, 65535, 7},
        '{"Content-Length:19\015\n", -1, 1, 65535, 19},
        '{"X-Mixed: abcz{`@[\015\015\n\n", -1, 0, 0, 0},
        '{"", 128, 0, 0, 0},
        '{"", 127, 0, 0, 0},
        '{"\015\nHTTP/1.1 302\015\n", -1, 1, 65535, 19}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_parser_model();
        keep_hdr    = 1'b0;
        limit_val   = '0;
        st_pos      = '0;
        status_done = 1'b0;
        len_pos     = '0;
        blank_pos   = '0;
        digits      = '0;
        num_is_len  = 1'b0;
        num_val     = '0;
        status_val  = '0;
        len_val     = '0;
        len_known   = 1'b0;
        body_flag   = 1'b0;
        body_left   = '0;
        room_left   = '0;
        done_flag   = 1'b0;
    endfunction

    function automatic t_resp predict_response(input logic [BYTE_W-1:0] b);
        t_resp       r;
        logic        fwd;
        logic [7:0]  c;
        int unsigned v;
        fwd = 1'b0;
        if (!done_flag) begin
            if (!body_flag) begin
                c = (b >= CH_LOWER_A && b <= CH_LOWER_Z) ? b - 8'd32 : b;
                // decimal number in progress
                if (digits != 0) begin
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        if (digits <= MAX_DIGITS) begin
                            v = 32'(num_val) * 10 + 32'(c - CH_ZERO);
                            num_val = (v > 65535) ? 16'hFFFF : v[15:0];
                            digits++;
                        end
                    end else if (!(c == CH_SPACE && digits == 1)) begin
                        if (digits > 1) begin
                            if (num_is_len) begin
                                len_val   = num_val;
                                len_known = 1'b1;
                            end else begin
                                status_val = num_val;
                            end
                        end
                        digits = '0;
                    end
                end
                if (!status_done) begin
                    if (st_pos < status_word.len() && c == status_word[st_pos]) begin
                        st_pos++;
                        if (st_pos == status_word.len()) begin
                            status_done = 1'b1;
                            st_pos      = '0;
                            digits      = 4'd1;
                            num_is_len  = 1'b0;
                            num_val     = '0;
                        end
                    end else begin
                        st_pos = '0;
                    end
                end
                if (len_pos < length_word.len() && c == length_word[len_pos]) begin
                    len_pos++;
                    if (len_pos == length_word.len()) begin
                        len_pos    = '0;
                        digits     = 4'd1;
                        num_is_len = 1'b1;
                        num_val    = '0;
                    end
                end else begin
                    len_pos = '0;
                end
                if (blank_pos < blank_word.len() && c == blank_word[blank_pos]) begin
                    blank_pos++;
                    if (blank_pos == blank_word.len()) begin
                        blank_pos = '0;
                        body_flag = 1'b1;
                        body_left = len_val;
                    end
                end else begin
                    blank_pos = '0;
                end
                fwd = keep_hdr;
                if (body_flag && len_known && len_val == 0) done_flag = 1'b1;
            end else begin
                fwd = 1'b1;
                if (len_known) begin
                    if (body_left != 0) body_left--;
                    if (body_left == 0) done_flag = 1'b1;
                end
            end
            if (fwd && limit_val != 0) begin
                if (room_left != 0) room_left--;
                if (room_left == 0) done_flag = 1'b1;
            end
        end
        r.data     = fwd ? b : '0;
        r.fwd      = fwd;
        r.in_body  = body_flag;
        r.status   = status_val;
        r.clen     = len_val;
        r.len_seen = len_known;
        r.done     = done_flag;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic logic [7:0] mixed_case(input logic [7:0] b);
        if (b >= 8'h41 && b <= 8'h5a && $urandom_range(1) == 1) return b | 8'h20;
        return b;
    endfunction

    // one byte transaction on the input stream, with random idle gaps ahead of it
    task automatic put_byte(input logic [BYTE_W-1:0] b);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_resp.push_back(predict_response(b));
        sent_cnt++;
    endtask

    task automatic hdr_byte(input logic [BYTE_W-1:0] b);
        // a stray LF after CR LF CR would end the header early
        if (!body_flag && blank_pos == 3 && b == CH_LF) b = 8'h78;
        put_byte(b);
    endtask

    task automatic send_word(input string w);
        int k;
        for (k = 0; k < w.len(); k++) hdr_byte(mixed_case(w[k]));
    endtask

    task automatic header_line();
        int kind;
        int n;
        kind = $urandom_range(99);
        hdr_byte(CH_CR);
        hdr_byte(CH_LF);
        if (kind < 40) begin
            send_word(cl_name);
            repeat ($urandom_range(2)) hdr_byte(CH_SPACE);
            if ($urandom_range(14) == 0) n = 0;
            else if ($urandom_range(7) == 0) n = $urandom_range(13, 6);
            else n = $urandom_range(5, 1);
            repeat (n) hdr_byte(8'(CH_ZERO + $urandom_range(9)));
            if ($urandom_range(1) == 1) hdr_byte(8'($urandom_range(126, 32)));
        end else if (kind < 70) begin
            repeat ($urandom_range(12, 1)) hdr_byte(mixed_case(8'($urandom_range(90, 65))));
            hdr_byte(":");
            hdr_byte(CH_SPACE);
            repeat ($urandom_range(20)) hdr_byte(8'($urandom_range(126, 32)));
        end else if (kind < 85) begin
            // truncated length field
            n = $urandom_range(14, 1);
            send_word(cl_name.substr(0, n - 1));
            repeat ($urandom_range(5)) hdr_byte(8'($urandom_range(126, 32)));
        end else if (kind < 90) begin
            send_word(status_word);
            repeat ($urandom_range(4, 1)) hdr_byte(8'(CH_ZERO + $urandom_range(9)));
        end else begin
            repeat ($urandom_range(8, 1)) hdr_byte(8'($urandom));
        end
    endtask

    // sender pause until the output side has caught up
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic reg_read(input logic idx, output logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        val = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [PDATA_W-1:0] val);
        logic [PDATA_W-1:0] rd;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_HDR_PASS) begin
            keep_hdr = val[0];
        end else begin
            limit_val = val[NUM_W-1:0];
            room_left = val[NUM_W-1:0];
        end
        reg_read(idx, rd);
        check_field(idx == REG_HDR_PASS ? "hdr_pass" : "byte_limit", val, rd);
    endtask

    // receiver: random tready, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req != hold_done) begin
            hold_done     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin : result_check
        t_resp want;
        if (i_rst_n && s_axis_tvalid && !s_axis_tready) stall_cnt++;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_resp.size() == 0) begin
                $error("result transaction with nothing expected: tdata %0h", m_axis_tdata);
                err_cnt++;
            end else begin
                want = pending_resp.pop_front();
                checked_cnt++;
                if (m_axis_tuser) fwd_cnt++;
                check_field("out_byte", want.data, m_axis_tdata[OD_BYTE_LO +: BYTE_W]);
                check_field("out_valid", want.fwd, m_axis_tuser);
                check_field("in_body", want.in_body, m_axis_tdata[OD_IN_BODY]);
                check_field("status_code", want.status, m_axis_tdata[OD_STATUS_LO +: NUM_W]);
                check_field("content_length", want.clen, m_axis_tdata[OD_LENGTH_LO +: NUM_W]);
                check_field("length_seen", want.len_seen, m_axis_tdata[OD_LEN_SEEN]);
                check_field("done_res", want.done, m_axis_tdata[OD_DONE]);
                check_field("tdata pad", 0, m_axis_tdata[OD_W-1:OD_USED_W]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
                     pending_resp.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        int                 j;
        int                 body_len;
        logic [PDATA_W-1:0] rd;
        string              len_txt;

        clear_parser_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        reg_read(REG_HDR_PASS, rd);
        check_field("hdr_pass after reset", 0, rd);
        reg_read(REG_BYTE_LIMIT, rd);
        check_field("byte_limit after reset", 0, rd);

        // directed rows: sender 37% idle, receiver 50% idle
        tx_idle_pct = 37;
        reg_write(REG_HDR_PASS, 1);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].raw >= 0) begin
                put_byte(8'(dir_rows[i].raw));
            end else begin
                for (j = 0; j < dir_rows[i].txt.len(); j++) put_byte(dir_rows[i].txt[j]);
            end
            if (dir_rows[i].chk && (status_val != 16'(dir_rows[i].st) ||
                                    len_val != 16'(dir_rows[i].ln))) begin
                $error("row %0d: expected status %0d length %0d, model has %0d %0d",
                       i, dir_rows[i].st, dir_rows[i].ln, status_val, len_val);
                err_cnt++;
            end
        end

        drain_results();
        reg_write(REG_BYTE_LIMIT, 65535);
        header_line();
        hold_req <= hold_req + 1;   // long receiver stall while bytes keep coming
        while (sent_cnt < 400) header_line();

        // receiver 37% idle, sender 50% idle
        drain_results();
        tx_idle_pct = 50;
        rx_idle_pct <= 37;
        reg_write(REG_HDR_PASS, 0);
        reg_write(REG_BYTE_LIMIT, 1);
        while (sent_cnt < 550) header_line();
        drain_results();
        while (sent_cnt < 720) header_line();

        // no idling on either side
        drain_results();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        reg_write(REG_HDR_PASS, 1);
        reg_write(REG_BYTE_LIMIT, 0);
        while (sent_cnt < 880) header_line();

        // body: final length, optional cap
        drain_results();
        reg_write(REG_HDR_PASS, $urandom_range(1));
        reg_write(REG_BYTE_LIMIT, ($urandom_range(1) == 1) ? 0 : $urandom_range(450, 150));
        body_len = $urandom_range(350, 200);
        len_txt  = $sformatf("%0d", body_len);
        hdr_byte(CH_CR);
        hdr_byte(CH_LF);
        send_word(cl_name);
        hdr_byte(CH_SPACE);
        send_word(len_txt);
        for (j = 0; j < blank_word.len(); j++) put_byte(blank_word[j]);
        j = 0;
        while (!done_flag && j < 600) begin
            put_byte(8'($urandom));
            j++;
        end
        // bytes after done must be dropped
        repeat (20) put_byte(8'($urandom));

        s_axis_tvalid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d input bytes, %0d results checked, %0d forwarded, %0d stall cycles",
                 sent_cnt, checked_cnt, fwd_cnt, stall_cnt);
        $display("final status %0d, length %0d, body %0b, done %0b",
                 status_val, len_val, body_flag, done_flag);
        if (err_cnt == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
